// File: rtl/plc_pkg.sv
// Package for the prefix code letter codec: symbol alphabet, code tables,
// mode codes and the result record shared by the encoder, decoder and top.
// No dependencies.
package plc_pkg;

    localparam int SYM_COUNT = 27;
    localparam int DATA_W    = 8;
    localparam int CW_W      = 15;
    localparam int LEN_W     = 4;
    localparam int MAX_LEN   = 15;

    // Operating mode as written through the configuration port
    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } t_mode;

    // One result request
    typedef struct packed {
        logic [CW_W-1:0]   codeword;
        logic [LEN_W-1:0]  code_length;
        logic [DATA_W-1:0] decoded_symbol;
        logic              decode_error;
    } t_result;

    // Alphabet ordered by frequency; index selects the code
    localparam logic [DATA_W-1:0] ALPHABET [SYM_COUNT] = '{
        8'h20, "E", "T", "A", "O", "I", "N", "S", "H", "R", "D", "L", "C", "U",
        "M", "W", "F", "G", "Y", "P", "B", "V", "K", "X", "J", "Q", "Z"
    };

    // Code length: two symbols per length, starting at two bits (one at fifteen)
    function automatic logic [LEN_W-1:0] sym_length(input int idx);
        int len;
        len = (idx >> 1) + 2;
        return LEN_W'(len);
    endfunction

    // Codeword, first bit in the msb of the used length
    function automatic logic [CW_W-1:0] sym_codeword(input int idx);
        int              len;
        logic [CW_W-1:0] cw;
        len = (idx >> 1) + 2;
        cw  = CW_W'(idx & 1);
        for (int k = 2; k < MAX_LEN; k++) begin
            if (k < len) begin
                cw = {cw[CW_W-2:0], 1'((k & 1))};
            end
        end
        cw = {cw[CW_W-2:0], 1'(((len & 1) == 0) ? 1 : 0)};
        return cw;
    endfunction

endpackage

// File: rtl/plc_encoder.sv
// Character to codeword lookup for the prefix code letter codec.
// Parallel compare against the alphabet; depends on plc_pkg.
module plc_encoder (
    input  logic [plc_pkg::DATA_W-1:0] i_char,
    output logic                       o_hit,
    output plc_pkg::t_result           o_result
);
    import plc_pkg::*;

    logic [SYM_COUNT-1:0] s_match;

    // One comparator per symbol
    always_comb begin
        for (int i = 0; i < SYM_COUNT; i++) begin
            s_match[i] = (i_char == ALPHABET[i]);
        end
    end

    // Select the code of the single matching symbol
    always_comb begin
        o_result = '0;
        for (int i = 0; i < SYM_COUNT; i++) begin
            if (s_match[i]) begin
                o_result.codeword    = o_result.codeword | sym_codeword(i);
                o_result.code_length = o_result.code_length | sym_length(i);
            end
        end
        o_hit = |s_match;
    end

endmodule

// File: rtl/plc_decoder.sv
// Bit-serial decoder for the prefix code letter codec: holds the gathered
// bits and count, matches them against all codewords each bit. Uses plc_pkg.
module plc_decoder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_bit,
    output logic             o_hit,
    output plc_pkg::t_result o_result
);
    import plc_pkg::*;

    logic [CW_W-1:0]      r_gather;
    logic [LEN_W-1:0]     r_count;
    logic [CW_W-1:0]      n_gather;
    logic [LEN_W-1:0]     n_count;
    logic [CW_W-1:0]      s_gather;
    logic [LEN_W-1:0]     s_count;
    logic [SYM_COUNT-1:0] s_match;
    logic                 s_full;

    // Bits gathered including the incoming one
    assign s_gather = {r_gather[CW_W-2:0], i_bit};
    assign s_count  = r_count + 1'b1;
    assign s_full   = (s_count == LEN_W'(MAX_LEN));

    // Compare against every codeword of the same length
    always_comb begin
        for (int i = 0; i < SYM_COUNT; i++) begin
            s_match[i] = (s_count == sym_length(i)) && (s_gather == sym_codeword(i));
        end
    end

    // Result and next state
    always_comb begin
        o_result = '0;
        for (int i = 0; i < SYM_COUNT; i++) begin
            if (s_match[i]) begin
                o_result.decoded_symbol = o_result.decoded_symbol | ALPHABET[i];
            end
        end
        o_result.decode_error = !(|s_match) && s_full;
        o_hit = (|s_match) || s_full;

        n_gather = r_gather;
        n_count  = r_count;
        if (i_fire) begin
            if (o_hit) begin
                n_gather = '0;
                n_count  = '0;
            end else begin
                n_gather = s_gather;
                n_count  = s_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gather <= '0;
            r_count  <= '0;
        end else begin
            r_gather <= n_gather;
            r_count  <= n_count;
        end
    end

    // Count is cleared on reaching the longest code, never held there
    a_count_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != LEN_W'(MAX_LEN))
        else $error("gather count reached max length");

    // A result always restarts the gather
    a_hit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_hit |=> r_count == '0 && r_gather == '0)
        else $error("gather not cleared after result");

    // An error is never given together with a symbol
    a_error_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.decode_error |-> o_result.decoded_symbol == '0)
        else $error("error and symbol together");

endmodule

// File: rtl/prefix_code_letter_codec.sv
// Top level of the prefix code letter codec: input register, encoder and
// decoder, result register. Depends on plc_pkg, plc_encoder, plc_decoder.
//
// Usage:
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes the mode:
//   0 encodes ASCII characters, 1 decodes code bits (lsb of i_data_in).
//   Write it only while no request is in flight.
//   Input channel (i_in_valid / o_in_ready): one request per cycle when ready.
//   Output channel (o_out_valid / i_out_ready) gives zero or one result per
//   request: unmapped characters and incomplete codes give none; fifteen bits
//   without a match give one result with o_decode_error set.
//   Path: a request passes the input register, then the result register.
//   Throughput: one request per cycle when the receiver does not stall; the
//   decoder updates its gathered bits in the same cycle it matches them.
//   Reset (synchronous, active low) selects encode mode and clears the
//   gathered bits. When the receiver stalls, the result register holds and
//   the input register keeps its request; o_in_ready drops once both are full.
module prefix_code_letter_codec (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_codec_mode,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [plc_pkg::DATA_W-1:0]  i_data_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [plc_pkg::CW_W-1:0]    o_codeword,
    output logic [plc_pkg::LEN_W-1:0]   o_code_length,
    output logic [plc_pkg::DATA_W-1:0]  o_decoded_symbol,
    output logic                        o_decode_error
);
    import plc_pkg::*;

    t_mode             r_mode;
    logic              r_in_valid;
    logic [DATA_W-1:0] r_in_data;
    logic              r_out_valid;
    t_result           r_out;

    logic    s_out_free;
    logic    s_fire;
    logic    s_enc_hit;
    logic    s_dec_hit;
    logic    s_res_hit;
    t_result s_enc_res;
    t_result s_dec_res;
    t_result s_res;

    // Handshake control
    assign o_cfg_ready = 1'b1;
    assign s_out_free  = !r_out_valid || i_out_ready;
    assign s_fire      = r_in_valid && s_out_free;
    assign o_in_ready  = !r_in_valid || s_out_free;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCODE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= t_mode'(i_cfg_codec_mode);
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_data_in;
        end
    end

    plc_encoder u_encoder (
        .i_char   (r_in_data),
        .o_hit    (s_enc_hit),
        .o_result (s_enc_res)
    );

    plc_decoder u_decoder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s_fire && (r_mode == MODE_DECODE)),
        .i_bit    (r_in_data[0]),
        .o_hit    (s_dec_hit),
        .o_result (s_dec_res)
    );

    // Pick the active path
    always_comb begin
        unique case (r_mode)
            MODE_ENCODE: begin
                s_res_hit = s_enc_hit;
                s_res     = s_enc_res;
            end
            MODE_DECODE: begin
                s_res_hit = s_dec_hit;
                s_res     = s_dec_res;
            end
            default: begin
                s_res_hit = 1'b0;
                s_res     = '0;
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_free) begin
            r_out_valid <= s_fire && s_res_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && s_res_hit) begin
            r_out <= s_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_codeword       = r_out.codeword;
    assign o_code_length    = r_out.code_length;
    assign o_decoded_symbol = r_out.decoded_symbol;
    assign o_decode_error   = r_out.decode_error;

    // Error results carry nothing else
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_decode_error |->
            o_decoded_symbol == '0 && o_code_length == '0 && o_codeword == '0)
        else $error("error result with payload");

    // Encode results carry a code of at least two bits
    a_enc_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_decode_error && o_decoded_symbol == '0 |->
            o_code_length >= LEN_W'(2))
        else $error("encode result with short length");

    // A request leaves the input register only when the result side has room
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> $stable(r_out))
        else $error("result overwritten while stalled");

endmodule

// File: tb/sv/prefix_code_checker_pkg.sv
// Result tracker for the prefix code letter codec testbench: predicts the
// encode and decode results of each accepted request and checks the outputs.
// Depends on plc_pkg for the mode codes, widths and the result record.
package prefix_code_checker_pkg;

    import plc_pkg::*;

    class prefix_code_checker;
        // Letters ordered by frequency; the position picks the code
        string             letters = " ETAOINSHRDLCUMWFGYPBVKXJQZ";
        logic [CW_W-1:0]   code_bits [SYM_COUNT];
        logic [LEN_W-1:0]  code_len [SYM_COUNT];
        t_mode             mode;
        logic [CW_W-1:0]   gathered;
        logic [LEN_W-1:0]  gathered_count;
        t_result           awaited [$];
        int                errors;

        // Build the code table: first bit from the index parity, inner bits
        // alternate (1 on odd positions), last bit set for even lengths
        function new();
            int   len;
            logic b;
            for (int i = 0; i < SYM_COUNT; i++) begin
                len          = i / 2 + 2;
                code_len[i]  = LEN_W'(len);
                code_bits[i] = '0;
                for (int k = 1; k <= len; k++) begin
                    if (k == 1) begin
                        b = i[0];
                    end else if (k == len) begin
                        b = ~len[0];
                    end else begin
                        b = k[0];
                    end
                    code_bits[i] = {code_bits[i][CW_W-2:0], b};
                end
            end
            mode           = MODE_ENCODE;
            gathered       = '0;
            gathered_count = '0;
            errors         = 0;
        endfunction

        // Mode change keeps the gathered decode bits
        function void set_mode(t_mode m);
            mode = m;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Work out what one accepted request produces
        function void note_request(logic [DATA_W-1:0] data);
            t_result r;
            bit      hit;
            r   = '0;
            hit = 1'b0;
            if (mode == MODE_ENCODE) begin
                for (int i = 0; i < SYM_COUNT; i++) begin
                    if (!hit && letters[i] == data) begin
                        r.codeword    = code_bits[i];
                        r.code_length = code_len[i];
                        hit           = 1'b1;
                    end
                end
                if (hit) begin
                    awaited = {awaited, r};
                end
            end else begin
                gathered       = {gathered[CW_W-2:0], data[0]};
                gathered_count = gathered_count + 1'b1;
                for (int i = 0; i < SYM_COUNT; i++) begin
                    if (!hit && code_len[i] == gathered_count && code_bits[i] == gathered) begin
                        r.decoded_symbol = letters[i];
                        hit              = 1'b1;
                    end
                end
                // fifteen bits and still no code: flag and start over
                if (!hit && gathered_count >= MAX_LEN) begin
                    r.decode_error = 1'b1;
                    hit            = 1'b1;
                end
                if (hit) begin
                    awaited        = {awaited, r};
                    gathered       = '0;
                    gathered_count = '0;
                end
            end
        endfunction

        // Compare one result against the oldest prediction
        function void check_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                $error("unexpected result: codeword %0h length %0d symbol %0h error %0b",
                       got.codeword, got.code_length, got.decoded_symbol, got.decode_error);
                errors++;
            end else begin
                want = awaited.pop_front();
                if (got.codeword !== want.codeword) begin
                    $error("codeword: expected %0h, got %0h", want.codeword, got.codeword);
                    errors++;
                end
                if (got.code_length !== want.code_length) begin
                    $error("code_length: expected %0d, got %0d",
                           want.code_length, got.code_length);
                    errors++;
                end
                if (got.decoded_symbol !== want.decoded_symbol) begin
                    $error("decoded_symbol: expected %0h, got %0h",
                           want.decoded_symbol, got.decoded_symbol);
                    errors++;
                end
                if (got.decode_error !== want.decode_error) begin
                    $error("decode_error: expected %0b, got %0b",
                           want.decode_error, got.decode_error);
                    errors++;
                end
            end
        endfunction
    endclass

endpackage

// File: tb/sv/prefix_code_letter_codec_test.sv
// Testbench top for prefix_code_letter_codec: directed and random encode and
// decode traffic with random stalls on both sides, checked by the tracker.
// Depends on plc_pkg, prefix_code_checker_pkg and the codec RTL.
module prefix_code_letter_codec_test;

    timeunit 1ns;
    timeprecision 1ps;

    import plc_pkg::*;
    import prefix_code_checker_pkg::*;

    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 125;
    localparam int QUIET_PHASE  = 10;
    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD    = 150;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_codec_mode;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [DATA_W-1:0]   i_data_in;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [CW_W-1:0]     o_codeword;
    logic [LEN_W-1:0]    o_code_length;
    logic [DATA_W-1:0]   o_decoded_symbol;
    logic                o_decode_error;

    prefix_code_checker board;
    bit                 quiet;
    bit                 hold_request;
    int                 sent_count;

    prefix_code_letter_codec dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_codec_mode (i_cfg_codec_mode),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_in        (i_data_in),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_codeword       (o_codeword),
        .o_code_length    (o_code_length),
        .o_decoded_symbol (o_decoded_symbol),
        .o_decode_error   (o_decode_error)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Send one request; returns at a falling edge with valid still high
    task automatic send_byte(input logic [DATA_W-1:0] data);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_data_in  = data;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        board.note_request(data);
        sent_count++;
        @(negedge i_clk);
    endtask

    // Code bits of one letter, first bit first, junk in the upper data bits
    task automatic send_symbol(input int idx);
        for (int k = board.code_len[idx] - 1; k >= 0; k--) begin
            send_byte({7'($urandom), board.code_bits[idx][k]});
        end
    endtask

    // Alternating 1010... never matches a code: error after fifteen bits
    task automatic send_unmatched();
        for (int k = 0; k < MAX_LEN; k++) begin
            send_byte({7'($urandom), ~k[0]});
        end
    endtask

    // Mode write once every result is out and the pipeline is empty
    task automatic write_mode(input t_mode m);
        i_in_valid = 1'b0;
        while (board.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid      = 1'b1;
        i_cfg_codec_mode = m;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        board.set_mode(m);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Stimulus
    initial begin
        t_mode m;
        int    pick;
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_codec_mode = MODE_ENCODE;
        i_in_valid       = 1'b0;
        i_data_in        = '0;
        quiet            = 1'b0;
        hold_request     = 1'b0;
        sent_count       = 0;
        board            = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: letters at both ends of the table, unmapped bytes
        write_mode(MODE_ENCODE);
        send_byte(" ");
        send_byte("E");
        send_byte("Z");
        send_byte("Q");
        send_byte("a");
        send_byte(8'h00);
        send_byte(8'hFF);

        // directed: shortest code with upper bits set, mode change mid-code,
        // and a full run of unmatched bits
        write_mode(MODE_DECODE);
        send_byte(8'hFE);
        send_byte(8'hFF);
        send_byte(8'h00);
        write_mode(MODE_ENCODE);
        send_byte("A");
        write_mode(MODE_DECODE);
        send_byte(8'h80);
        send_byte(8'h00);
        send_unmatched();

        // random phases, alternating mode; the last ones run without idling
        for (int p = 0; p < PHASES; p++) begin
            m = p[0] ? MODE_ENCODE : MODE_DECODE;
            write_mode(m);
            quiet = (p >= QUIET_PHASE);
            if (p == 1) begin
                hold_request = 1'b1;
            end
            sent_count = 0;
            while (sent_count < PHASE_ITEMS) begin
                pick = $urandom_range(0, 19);
                if (m == MODE_ENCODE) begin
                    if (pick < 16) begin
                        send_byte(board.letters[$urandom_range(0, SYM_COUNT - 1)]);
                    end else begin
                        send_byte(8'($urandom));
                    end
                end else begin
                    if (pick < 16) begin
                        send_symbol($urandom_range(0, SYM_COUNT - 1));
                    end else if (pick < 19) begin
                        repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
                    end else begin
                        send_unmatched();
                    end
                end
            end
        end

        // drain and report
        i_in_valid = 1'b0;
        while (board.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);
        if (board.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Receiver: random stalls, one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready  = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
    end

    // Check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_result({o_codeword, o_code_length, o_decoded_symbol, o_decode_error});
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
rtl/plc_pkg.sv
rtl/plc_encoder.sv
rtl/plc_decoder.sv
rtl/prefix_code_letter_codec.sv
tb/sv/prefix_code_checker_pkg.sv
tb/sv/prefix_code_letter_codec_test.sv
